>>> hw/rtl/hsmp_pkg.sv
// ----------------------------------------------------------------------------
// hsmp_pkg
// Types and codes shared by the slot map pool modules.
// ----------------------------------------------------------------------------
package hsmp_pkg;

  localparam int KindW = 3;
  localparam int StatW = 3;

  localparam logic [KindW-1:0] KIND_ADD    = 3'd0;
  localparam logic [KindW-1:0] KIND_REMOVE = 3'd1;
  localparam logic [KindW-1:0] KIND_LOOKUP = 3'd2;
  localparam logic [KindW-1:0] KIND_SETSH  = 3'd3;
  localparam logic [KindW-1:0] KIND_REFR   = 3'd4;
  localparam logic [KindW-1:0] KIND_READ   = 3'd5;

  localparam logic [StatW-1:0] ST_OK      = 3'd0;
  localparam logic [StatW-1:0] ST_FULL    = 3'd1;
  localparam logic [StatW-1:0] ST_OWNER   = 3'd2;
  localparam logic [StatW-1:0] ST_EMPTY   = 3'd3;
  localparam logic [StatW-1:0] ST_NOTFND  = 3'd4;
  localparam logic [StatW-1:0] ST_BADPOS  = 3'd5;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  handle_id;
    logic [15:0] handle_owner;
    logic        casts_shadow;
    logic        mark_dirty;
    logic [3:0]  list_position;
  } req_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] status;
    logic [5:0] new_handle;
    logic [5:0] slot_index;
    logic       move_valid;
    logic [5:0] move_source;
    logic       needs_refresh;
    logic [5:0] shadow_entry;
    logic [4:0] shadow_total;
  } rsp_t;

endpackage

>>> hw/rtl/hsmp_ram.sv
// ----------------------------------------------------------------------------
// hsmp_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module hsmp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/handle_slot_map_pool_top.sv
// ----------------------------------------------------------------------------
// handle_slot_map_pool_top
// Slot map pool: handles over a dense slot array, fifo free list of handles,
// shadow caster list. One shared memory read port per store, one sequencer.
// ----------------------------------------------------------------------------
//  channel | signals                      | payload
//  in      | in_valid / in_ready          | req_t
//  out     | out_valid / out_ready        | rsp_t
//  cfg     | cfg_we / cfg_data            | owner_id
//
// Steps from input transfer to result valid: add, lookup, set_shadow and unknown
// kinds read and then decode; read answers from the shadow list read; refresh
// ends at once when clean and scans every live slot when dirty; remove searches
// the shadow list entry by entry when the removed slot casts a shadow.
// After reset a clearing pass fills the free list with every handle, in_ready low.
// A finished result sits in the output register; in_ready returns the cycle
// after it is transferred.
module handle_slot_map_pool_top
  import hsmp_pkg::*;
#(
  parameter int CAPACITY     = 64,
  parameter int SHADOW_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  req_t        in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output rsp_t        out_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data
);
  localparam int HW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int TW = CW + 1;
  localparam int SW = (SHADOW_SLOTS > 1) ? $clog2(SHADOW_SLOTS) : 1;
  localparam int SCW = $clog2(SHADOW_SLOTS + 1);

  typedef enum logic [12:0] {
    S_INIT  = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_RD    = 13'b0000000000100,
    S_DEC   = 13'b0000000001000,
    S_SRCH  = 13'b0000000010000,
    S_SRCHW = 13'b0000000100000,
    S_SWAPR = 13'b0000001000000,
    S_SWAPW = 13'b0000010000000,
    S_LAST  = 13'b0000100000000,
    S_MOVE  = 13'b0001000000000,
    S_SCAN  = 13'b0010000000000,
    S_SCANW = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  state_t state;
  req_t   req;
  rsp_t   rsp;
  logic [15:0] owner_id;

  logic [HW-1:0] free_head;
  logic [CW-1:0] free_count;
  logic [CW-1:0] live_count;
  logic [SCW-1:0] shadow_count;
  logic          pool_dirty;
  logic [CAPACITY-1:0] map_valid;
  logic [CW-1:0] idx;
  logic [HW-1:0] slot;
  logic [HW-1:0] last_slot;
  logic [SCW-1:0] sidx;

  // memory ports
  logic          fh_we;  logic [HW-1:0] fh_wa, fh_wd, fh_ra, fh_rd;
  logic          hm_we;  logic [HW-1:0] hm_wa, hm_wd, hm_ra, hm_rd;
  logic          so_we;  logic [HW-1:0] so_wa, so_wd, so_ra, so_rd;
  logic          sf_we;  logic [HW-1:0] sf_wa, sf_ra;  logic sf_wd, sf_rd;
  logic          sl_we;  logic [SW-1:0] sl_wa, sl_ra;  logic [HW-1:0] sl_wd, sl_rd;

  // decode helpers
  logic [TW-1:0] tail_sum;
  logic [HW-1:0] tail;
  logic          hid_in_range;
  logic [HW-1:0] hid;
  logic          found;
  logic          add_room;
  logic          shadow_room;

  hsmp_ram #(.Width(HW), .Depth(CAPACITY)) u_free (
    .clk, .we(fh_we), .waddr(fh_wa), .wdata(fh_wd), .raddr(fh_ra), .rdata(fh_rd));
  hsmp_ram #(.Width(HW), .Depth(CAPACITY)) u_map (
    .clk, .we(hm_we), .waddr(hm_wa), .wdata(hm_wd), .raddr(hm_ra), .rdata(hm_rd));
  hsmp_ram #(.Width(HW), .Depth(CAPACITY)) u_owner (
    .clk, .we(so_we), .waddr(so_wa), .wdata(so_wd), .raddr(so_ra), .rdata(so_rd));
  hsmp_ram #(.Width(1), .Depth(CAPACITY)) u_flag (
    .clk, .we(sf_we), .waddr(sf_wa), .wdata(sf_wd), .raddr(sf_ra), .rdata(sf_rd));
  hsmp_ram #(.Width(HW), .Depth(SHADOW_SLOTS)) u_shadow (
    .clk, .we(sl_we), .waddr(sl_wa), .wdata(sl_wd), .raddr(sl_ra), .rdata(sl_rd));

  assign in_ready  = (state == S_IDLE) && !out_valid;
  assign out_data  = rsp;

  // free list tail for recycling
  assign tail_sum = TW'(free_head) + TW'(free_count);
  assign tail = (tail_sum >= TW'(CAPACITY)) ? HW'(tail_sum - TW'(CAPACITY))
                                            : HW'(tail_sum);
  assign hid_in_range = ({26'd0, req.handle_id} < 32'(CAPACITY));
  assign hid = HW'(req.handle_id);

  // handle mapped to a live slot, valid while the map read data is up
  assign found = hid_in_range && map_valid[hid] && (CW'(hm_rd) < live_count);
  assign add_room = !(live_count >= CW'(CAPACITY) || free_count == '0);
  assign shadow_room = (shadow_count < SCW'(SHADOW_SLOTS));

  // memory control
  always_comb begin
    fh_we = 1'b0; fh_wa = free_head; fh_wd = '0; fh_ra = free_head;
    hm_we = 1'b0; hm_wa = hid; hm_wd = '0; hm_ra = hid;
    so_we = 1'b0; so_wa = slot; so_wd = '0; so_ra = last_slot;
    sf_we = 1'b0; sf_wa = slot; sf_wd = 1'b0; sf_ra = slot;
    sl_we = 1'b0; sl_wa = '0; sl_wd = '0; sl_ra = SW'(sidx);
    unique case (state)
      S_INIT: begin
        fh_we = 1'b1; fh_wa = HW'(idx); fh_wd = HW'(idx);
      end
      S_RD: sl_ra = SW'(req.list_position);
      S_DEC: begin
        if (req.kind == KIND_ADD && add_room) begin
          hm_we = 1'b1; hm_wa = fh_rd; hm_wd = HW'(live_count);
          so_we = 1'b1; so_wa = HW'(live_count); so_wd = fh_rd;
          sf_we = 1'b1; sf_wa = HW'(live_count); sf_wd = req.casts_shadow;
          sl_we = req.casts_shadow && shadow_room;
          sl_wa = SW'(shadow_count); sl_wd = HW'(live_count);
        end else if (req.kind == KIND_SETSH && found) begin
          sf_we = 1'b1; sf_wa = hm_rd; sf_wd = req.casts_shadow;
        end
      end
      S_SWAPR: sl_ra = SW'(shadow_count - SCW'(1));
      S_SWAPW: begin
        sl_we = 1'b1; sl_wa = SW'(sidx); sl_wd = sl_rd;
      end
      S_LAST: sf_ra = last_slot;
      S_MOVE: begin
        so_we = (slot != last_slot); so_wa = slot; so_wd = so_rd;
        sf_we = (slot != last_slot); sf_wa = slot; sf_wd = sf_rd;
        hm_we = (slot != last_slot); hm_wa = so_rd; hm_wd = slot;
        fh_we = (free_count < CW'(CAPACITY)); fh_wa = tail; fh_wd = hid;
      end
      S_SCAN: sf_ra = HW'(idx);
      S_SCANW: begin
        sl_we = sf_rd && shadow_room;
        sl_wa = SW'(shadow_count); sl_wd = HW'(idx);
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT; idx <= '0; free_head <= '0; free_count <= CW'(CAPACITY);
      live_count <= '0; shadow_count <= '0; pool_dirty <= 1'b0; map_valid <= '0;
      out_valid <= 1'b0; owner_id <= '0;
    end else begin
      if (cfg_we) owner_id <= cfg_data;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_INIT: begin
          idx <= idx + CW'(1);
          if (idx == CW'(CAPACITY - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            req <= in_data; state <= S_RD; rsp <= '0;
          end
        end
        S_RD: begin
          // map, free list and shadow list reads issued this cycle
          if (req.kind == KIND_REFR) begin
            rsp.ok <= 1'b1;
            if (pool_dirty) begin
              shadow_count <= '0; idx <= '0; state <= S_SCAN; rsp.needs_refresh <= 1'b1;
            end else state <= S_DONE;
          end else if (req.kind == KIND_READ) begin
            state <= S_DONE;
          end else state <= S_DEC;
        end
        S_DEC: begin
          case (req.kind)
            KIND_ADD: begin
              state <= S_DONE;
              if (!add_room) rsp.status <= ST_FULL;
              else begin
                free_head <= (free_head == HW'(CAPACITY - 1)) ? '0 : free_head + HW'(1);
                free_count <= free_count - CW'(1);
                live_count <= live_count + CW'(1);
                map_valid[fh_rd] <= 1'b1;
                if (req.casts_shadow && shadow_room)
                  shadow_count <= shadow_count + SCW'(1);
                pool_dirty <= 1'b1;
                rsp.ok <= 1'b1; rsp.new_handle <= 6'(fh_rd);
                rsp.slot_index <= 6'(live_count);
              end
            end
            KIND_REMOVE: begin
              if (req.handle_owner != owner_id) begin
                rsp.status <= ST_OWNER; state <= S_DONE;
              end else if (live_count == '0) begin
                rsp.status <= ST_EMPTY; state <= S_DONE;
              end else if (!found) begin
                rsp.status <= ST_NOTFND; state <= S_DONE;
              end else begin
                slot <= hm_rd;
                last_slot <= HW'(live_count - CW'(1));
                map_valid[hid] <= 1'b0;
                sidx <= '0;
                rsp.ok <= 1'b1; rsp.slot_index <= 6'(hm_rd);
                state <= S_SRCH;
              end
            end
            KIND_LOOKUP: begin
              state <= S_DONE;
              if (found) begin
                if (req.mark_dirty) pool_dirty <= 1'b1;
                rsp.ok <= 1'b1; rsp.slot_index <= 6'(hm_rd);
              end else rsp.status <= ST_NOTFND;
            end
            KIND_SETSH: begin
              state <= S_DONE;
              if (found) begin
                pool_dirty <= 1'b1;
                rsp.ok <= 1'b1; rsp.slot_index <= 6'(hm_rd);
              end else rsp.status <= ST_NOTFND;
            end
            default: begin
              rsp.status <= ST_NOTFND; state <= S_DONE;
            end
          endcase
        end
        // shadow list search: flag of the removed slot and one entry per pass
        S_SRCH: state <= S_SRCHW;
        S_SRCHW: begin
          if (!sf_rd || sidx >= shadow_count) state <= S_LAST;
          else if (sl_rd == slot) state <= S_SWAPR;
          else begin
            sidx <= sidx + SCW'(1); state <= S_SRCH;
          end
        end
        S_SWAPR: state <= S_SWAPW;
        S_SWAPW: begin
          shadow_count <= shadow_count - SCW'(1); state <= S_LAST;
        end
        // move the last dense entry into the hole and recycle the handle
        S_LAST: state <= S_MOVE;
        S_MOVE: begin
          if (slot != last_slot) begin
            map_valid[so_rd] <= 1'b1;
            rsp.move_valid <= 1'b1; rsp.move_source <= 6'(last_slot);
          end
          live_count <= live_count - CW'(1);
          if (free_count < CW'(CAPACITY)) free_count <= free_count + CW'(1);
          pool_dirty <= 1'b1;
          state <= S_DONE;
        end
        // refresh scan over the live slots
        S_SCAN: begin
          if (idx >= live_count) begin
            pool_dirty <= 1'b0; state <= S_DONE;
          end else state <= S_SCANW;
        end
        S_SCANW: begin
          if (sf_rd && shadow_room) shadow_count <= shadow_count + SCW'(1);
          idx <= idx + CW'(1);
          state <= S_SCAN;
        end
        S_DONE: begin
          if (req.kind == KIND_READ) begin
            if (32'(req.list_position) < 32'(shadow_count)) begin
              rsp.ok <= 1'b1; rsp.shadow_entry <= 6'(sl_rd);
            end else rsp.status <= ST_BADPOS;
          end
          rsp.shadow_total <= 5'(shadow_count);
          out_valid <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/hsmp_checker.sv
// ----------------------------------------------------------------------------
// hsmp_checker
// Port-level checks on the slot map pool, bound to the top level.
// ----------------------------------------------------------------------------
module hsmp_checker
  import hsmp_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input rsp_t out_data
);
  // no new transfer while a result waits
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken with result pending");

  // failed results carry a nonzero status
  a_fail_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.ok |-> out_data.status != ST_OK)
    else $error("failure without status");

  // a held result does not change
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed");

  // a waiting input stays offered
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid) else $error("input dropped before transfer");
endmodule

bind handle_slot_map_pool_top hsmp_checker u_hsmp_checker (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .out_data);
